// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the segment intersection RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/segint_pkg.sv
// ---------------------------------------------------------------------------
// segint_pkg
// Shared types and constants of the segment intersection test.
// ---------------------------------------------------------------------------
package segint_pkg;

  // width of a point identifier
  localparam int ID_BITS = 16;

  // sign of an orientation determinant
  typedef enum logic [1:0] {
    ORIENT_ZERO = 2'd0,
    ORIENT_POS  = 2'd1,
    ORIENT_NEG  = 2'd2
  } orient_t;

  // flags of one result word
  typedef struct packed {
    logic intersects;
    logic shares_endpoint;
  } seg_result_t;

endpackage

// File: src/segint_orient.sv
// ---------------------------------------------------------------------------
// segint_orient
// Exact sign of (q.y-p.y)*(r.x-q.x) - (q.x-p.x)*(r.y-q.y) for three points.
// ---------------------------------------------------------------------------
module segint_orient
  import segint_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  logic signed [COORD_BITS-1:0] r_x,
  input  logic signed [COORD_BITS-1:0] r_y,
  output orient_t                      code
);

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DET_BITS  = PROD_BITS + 1;

  logic signed [DIFF_BITS-1:0] dy_pq;
  logic signed [DIFF_BITS-1:0] dx_qr;
  logic signed [DIFF_BITS-1:0] dx_pq;
  logic signed [DIFF_BITS-1:0] dy_qr;
  logic signed [PROD_BITS-1:0] prod_u;
  logic signed [PROD_BITS-1:0] prod_v;
  logic signed [DET_BITS-1:0]  det;

  // coordinate differences, one bit wider so they never wrap
  assign dy_pq = DIFF_BITS'(q_y) - DIFF_BITS'(p_y);
  assign dx_qr = DIFF_BITS'(r_x) - DIFF_BITS'(q_x);
  assign dx_pq = DIFF_BITS'(q_x) - DIFF_BITS'(p_x);
  assign dy_qr = DIFF_BITS'(r_y) - DIFF_BITS'(q_y);

  // two full-width cross products
  assign prod_u = PROD_BITS'(dy_pq) * PROD_BITS'(dx_qr);
  assign prod_v = PROD_BITS'(dx_pq) * PROD_BITS'(dy_qr);

  // determinant at full width
  assign det = DET_BITS'(prod_u) - DET_BITS'(prod_v);

  // sign code
  always_comb begin
    if (det[DET_BITS-1]) begin
      code = ORIENT_NEG;
    end else if (det != '0) begin
      code = ORIENT_POS;
    end else begin
      code = ORIENT_ZERO;
    end
  end

endmodule

// File: src/segint_eval.sv
// ---------------------------------------------------------------------------
// segint_eval
// Combinational decision for one segment pair: shared identifiers,
// straddle test and collinear bounding-box test.
// ---------------------------------------------------------------------------
module segint_eval
  import segint_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        [ID_BITS-1:0]    a_start_id,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic        [ID_BITS-1:0]    a_end_id,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic        [ID_BITS-1:0]    b_start_id,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic        [ID_BITS-1:0]    b_end_id,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  output seg_result_t                  result
);

  orient_t o1;
  orient_t o2;
  orient_t o3;
  orient_t o4;
  logic    shared;
  logic    straddle;
  logic    touch;

  // q inside the closed bounding box of p and r
  function automatic logic in_box(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] qx,
    input logic signed [COORD_BITS-1:0] qy,
    input logic signed [COORD_BITS-1:0] rx,
    input logic signed [COORD_BITS-1:0] ry
  );
    logic signed [COORD_BITS-1:0] xlo;
    logic signed [COORD_BITS-1:0] xhi;
    logic signed [COORD_BITS-1:0] ylo;
    logic signed [COORD_BITS-1:0] yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px < rx) ? rx : px;
    ylo = (py < ry) ? py : ry;
    yhi = (py < ry) ? ry : py;
    return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
  endfunction

  // four orientation units
  segint_orient #(.COORD_BITS(COORD_BITS)) u_orient_1 (
    .p_x(a_start_x), .p_y(a_start_y), .q_x(a_end_x), .q_y(a_end_y),
    .r_x(b_start_x), .r_y(b_start_y), .code(o1)
  );

  segint_orient #(.COORD_BITS(COORD_BITS)) u_orient_2 (
    .p_x(a_start_x), .p_y(a_start_y), .q_x(a_end_x), .q_y(a_end_y),
    .r_x(b_end_x), .r_y(b_end_y), .code(o2)
  );

  segint_orient #(.COORD_BITS(COORD_BITS)) u_orient_3 (
    .p_x(b_start_x), .p_y(b_start_y), .q_x(b_end_x), .q_y(b_end_y),
    .r_x(a_start_x), .r_y(a_start_y), .code(o3)
  );

  segint_orient #(.COORD_BITS(COORD_BITS)) u_orient_4 (
    .p_x(b_start_x), .p_y(b_start_y), .q_x(b_end_x), .q_y(b_end_y),
    .r_x(a_end_x), .r_y(a_end_y), .code(o4)
  );

  // any common identifier
  assign shared = (a_start_id == b_start_id) || (a_start_id == b_end_id) ||
                  (a_end_id == b_start_id) || (a_end_id == b_end_id);

  // proper crossing
  assign straddle = (o1 != o2) && (o3 != o4);

  // collinear endpoint lying on the other segment
  assign touch =
    ((o1 == ORIENT_ZERO) &&
     in_box(a_start_x, a_start_y, b_start_x, b_start_y, a_end_x, a_end_y)) ||
    ((o2 == ORIENT_ZERO) &&
     in_box(a_start_x, a_start_y, b_end_x, b_end_y, a_end_x, a_end_y)) ||
    ((o3 == ORIENT_ZERO) &&
     in_box(b_start_x, b_start_y, a_start_x, a_start_y, b_end_x, b_end_y)) ||
    ((o4 == ORIENT_ZERO) &&
     in_box(b_start_x, b_start_y, a_end_x, a_end_y, b_end_x, b_end_y));

  assign result.intersects      = !shared && (straddle || touch);
  assign result.shares_endpoint = shared;

endmodule

// File: src/segment_intersection_test.sv
// Segment intersection test: takes one pair of segments per clock while
// in_stall is low and gives one result word per pair, in order. Throughput
// is one pair per cycle while the output side does not stall. A word taken
// into the input register runs through the eight orientation multipliers
// and is then taken into the result register, which raises out_valid.
// in_stall rises only when both registers hold a word and the output
// side stalls.
// ---------------------------------------------------------------------------
// segment_intersection_test
// Top level: input register, orientation/bounding-box logic, result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test
  import segint_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic        [ID_BITS-1:0]    a_start_id,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic        [ID_BITS-1:0]    a_end_id,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic        [ID_BITS-1:0]    b_start_id,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic        [ID_BITS-1:0]    b_end_id,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         intersects,
  output logic                         shares_endpoint
);

  logic                         in_full;
  logic        [ID_BITS-1:0]    in_a_start_id;
  logic signed [COORD_BITS-1:0] in_a_start_x;
  logic signed [COORD_BITS-1:0] in_a_start_y;
  logic        [ID_BITS-1:0]    in_a_end_id;
  logic signed [COORD_BITS-1:0] in_a_end_x;
  logic signed [COORD_BITS-1:0] in_a_end_y;
  logic        [ID_BITS-1:0]    in_b_start_id;
  logic signed [COORD_BITS-1:0] in_b_start_x;
  logic signed [COORD_BITS-1:0] in_b_start_y;
  logic        [ID_BITS-1:0]    in_b_end_id;
  logic signed [COORD_BITS-1:0] in_b_end_x;
  logic signed [COORD_BITS-1:0] in_b_end_y;
  logic                         advance;
  logic                         in_free;
  seg_result_t                  eval_result;

  // result register can take a word
  assign advance  = !out_valid || !out_stall;
  // input register can take a word
  assign in_free  = !in_full || advance;
  assign in_stall = !in_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_free) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_a_start_id <= a_start_id;
      in_a_start_x  <= a_start_x;
      in_a_start_y  <= a_start_y;
      in_a_end_id   <= a_end_id;
      in_a_end_x    <= a_end_x;
      in_a_end_y    <= a_end_y;
      in_b_start_id <= b_start_id;
      in_b_start_x  <= b_start_x;
      in_b_start_y  <= b_start_y;
      in_b_end_id   <= b_end_id;
      in_b_end_x    <= b_end_x;
      in_b_end_y    <= b_end_y;
    end
  end

  // intersection decision
  segint_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .a_start_id (in_a_start_id),
    .a_start_x  (in_a_start_x),
    .a_start_y  (in_a_start_y),
    .a_end_id   (in_a_end_id),
    .a_end_x    (in_a_end_x),
    .a_end_y    (in_a_end_y),
    .b_start_id (in_b_start_id),
    .b_start_x  (in_b_start_x),
    .b_start_y  (in_b_start_y),
    .b_end_id   (in_b_end_id),
    .b_end_x    (in_b_end_x),
    .b_end_y    (in_b_end_y),
    .result     (eval_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      intersects      <= eval_result.intersects;
      shares_endpoint <= eval_result.shares_endpoint;
    end
  end

  // checks
  `ASSERT_IMPLIES(a_no_hit_on_shared, clk, rst, out_valid && intersects, !shares_endpoint)
  `ASSERT_IMPLIES(a_stall_only_full, clk, rst, in_stall, in_full && out_valid && out_stall)
  `ASSERT_NEXT(a_accept_fills_input, clk, rst, in_valid && !in_stall, in_full)
  `ASSERT_NEXT(a_input_moves_out, clk, rst, in_full && advance, out_valid)

endmodule
